// ===== design/lobl_pkg.sv =====
package lobl_pkg;

    localparam int KEY_W   = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;

    // command field codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    // status codes
    localparam logic [1:0] ST_APPLIED   = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [PRICE_W-1:0] NO_BID = '0;
    localparam logic [PRICE_W-1:0] NO_ASK = '1;

    typedef enum logic [1:0] {
        K_ADD,
        K_REMOVE,
        K_MODIFY,
        K_NOP
    } kind_t;

    // one classified command word, as queued between front and back
    typedef struct packed {
        kind_t               kind;
        logic [KEY_W-1:0]    key;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    size;
        logic                side;
    } cmd_word_t;

    typedef struct packed {
        logic                valid;
        logic                side;
        logic [QTY_W-1:0]    qty;
        logic [PRICE_W-1:0]  price;
        logic [KEY_W-1:0]    key;
    } ent_t;

endpackage

// ===== design/lobl_front.sv =====
module lobl_front
    import lobl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [KEY_W-1:0]   s_order_key,
    input  logic [PRICE_W-1:0] s_limit_price,
    input  logic [QTY_W-1:0]   s_order_size,
    input  logic               s_buy_side,
    output logic               q_valid,
    output cmd_word_t          q_word,
    input  logic               q_pop
);

    cmd_word_t  fifo_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    cmd_word_t  in_word;
    kind_t      in_kind;

    always_comb begin
        case (s_command)
            CMD_ADD:    in_kind = K_ADD;
            CMD_REMOVE: in_kind = K_REMOVE;
            CMD_MODIFY: in_kind = K_MODIFY;
            default:    in_kind = K_NOP;
        endcase
        in_word = '{kind: in_kind, key: s_order_key, price: s_limit_price,
                    size: s_order_size, side: s_buy_side};
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != 2'd0) else $error("pop from empty queue");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !q_pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("push lost");

endmodule

// ===== design/lobl_engine.sv =====
module lobl_engine
    import lobl_pkg::*;
#(
    parameter int MAX_ORDERS = 1024,
    parameter int MAX_LEVELS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_word_t          q_word,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PRICE_W-1:0] m_best_bid,
    output logic [PRICE_W-1:0] m_best_ask,
    output logic [1:0]         m_status
);

    localparam int EW   = $clog2(MAX_ORDERS);
    localparam int LW   = $clog2(MAX_LEVELS);
    localparam int MAXD = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
    localparam int AW   = $clog2(MAXD);
    localparam int CW   = $clog2(MAXD + 1);
    localparam int CNTW = $clog2(MAX_ORDERS + 1);
    localparam logic [CW-1:0] N_ENT = CW'(MAX_ORDERS);
    localparam logic [CW-1:0] N_LVL = CW'(MAX_LEVELS);

    typedef struct packed {
        logic               valid;
        logic               side;
        logic [CNTW-1:0]    count;
        logic [PRICE_W-1:0] price;
    } lvl_t;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_ESCAN, S_DSCAN, S_ASCAN, S_TSCAN, S_FIN
    } state_t;

    ent_t ent_mem [MAX_ORDERS];
    lvl_t lvl_mem [MAX_LEVELS];
    ent_t ent_rd_reg;
    lvl_t lvl_rd_reg;

    state_t             state_reg;
    cmd_word_t          cmd_reg;
    logic [CW-1:0]      cnt_reg;
    logic               rv_reg;
    logic [AW-1:0]      ridx_reg;
    logic [1:0]         status_reg;
    logic               hit_found_reg, free_found_reg;
    logic [EW-1:0]      hit_idx_reg, free_idx_reg;
    logic [PRICE_W-1:0] hit_price_reg;
    logic               hit_side_reg;
    logic               lm_found_reg, lf_found_reg;
    logic [LW-1:0]      lm_idx_reg, lf_idx_reg;
    logic [CNTW-1:0]    lm_cnt_reg;
    logic [PRICE_W-1:0] bid_acc_reg, ask_acc_reg;
    logic [PRICE_W-1:0] top_bid_reg, top_ask_reg;
    logic               m_valid_reg;
    logic [PRICE_W-1:0] m_bid_reg, m_ask_reg;
    logic [1:0]         m_status_reg;

    logic          scanning, scan_done;
    logic [CW-1:0] scan_depth;
    logic          ent_we, lvl_we;
    logic [EW-1:0] ent_waddr;
    logic [LW-1:0] lvl_waddr;
    ent_t          ent_wdata;
    lvl_t          lvl_wdata;
    logic [CNTW-1:0] cnt_dec;
    logic          out_load;
    logic [PRICE_W-1:0] lv_price_want;
    logic          lv_side_want;

    assign scanning   = (state_reg == S_ESCAN) || (state_reg == S_DSCAN) ||
                        (state_reg == S_ASCAN) || (state_reg == S_TSCAN);
    assign scan_depth = (state_reg == S_ESCAN) ? N_ENT : N_LVL;
    assign scan_done  = scanning && (cnt_reg == scan_depth) && !rv_reg;
    assign cnt_dec    = (lm_cnt_reg != '0) ? lm_cnt_reg - CNTW'(1) : '0;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign out_load   = (state_reg == S_FIN) && (!m_valid_reg || m_ready);
    assign lv_price_want = (state_reg == S_DSCAN) ? hit_price_reg : cmd_reg.price;
    assign lv_side_want  = (state_reg == S_DSCAN) ? hit_side_reg : cmd_reg.side;

    // memory write controls
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = hit_idx_reg;
        ent_wdata = '{valid: 1'b1, side: cmd_reg.side, qty: cmd_reg.size,
                      price: cmd_reg.price, key: cmd_reg.key};
        lvl_we    = 1'b0;
        lvl_waddr = lm_idx_reg;
        lvl_wdata = '{valid: 1'b1, side: cmd_reg.side, count: lm_cnt_reg + CNTW'(1),
                      price: cmd_reg.price};
        case (state_reg)
            S_CLR: begin
                ent_we    = cnt_reg < N_ENT;
                ent_waddr = cnt_reg[EW-1:0];
                ent_wdata = '0;
                lvl_we    = cnt_reg < N_LVL;
                lvl_waddr = cnt_reg[LW-1:0];
                lvl_wdata = '0;
            end
            S_ESCAN: begin
                ent_we    = scan_done && (cmd_reg.kind == K_MODIFY) && hit_found_reg;
                ent_wdata = '{valid: 1'b1, side: hit_side_reg, qty: cmd_reg.size,
                              price: hit_price_reg, key: cmd_reg.key};
            end
            S_DSCAN: begin
                ent_we    = scan_done;
                ent_wdata = '0;
                lvl_we    = scan_done && lm_found_reg;
                lvl_wdata = '{valid: cnt_dec != '0, side: hit_side_reg,
                              count: cnt_dec, price: hit_price_reg};
            end
            S_ASCAN: begin
                ent_waddr = free_idx_reg;
                ent_we    = scan_done && (lm_found_reg || lf_found_reg);
                lvl_we    = ent_we;
                if (!lm_found_reg) begin
                    lvl_waddr       = lf_idx_reg;
                    lvl_wdata.count = CNTW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= ent_mem[cnt_reg[EW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        lvl_rd_reg <= lvl_mem[cnt_reg[LW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            cnt_reg     <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            top_bid_reg <= NO_BID;
            top_ask_reg <= NO_ASK;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // read pipeline of the scans
            rv_reg <= 1'b0;
            if (scanning && cnt_reg < scan_depth) begin
                rv_reg   <= 1'b1;
                ridx_reg <= cnt_reg[AW-1:0];
                cnt_reg  <= cnt_reg + CW'(1);
            end
            case (state_reg)
                S_CLR: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(MAXD - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg        <= q_word;
                        status_reg     <= ST_APPLIED;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        cnt_reg        <= '0;
                        state_reg      <= S_ESCAN;
                    end
                end
                S_ESCAN: begin
                    if (rv_reg) begin
                        if (ent_rd_reg.valid && ent_rd_reg.key == cmd_reg.key &&
                            !hit_found_reg) begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= ridx_reg[EW-1:0];
                            hit_price_reg <= ent_rd_reg.price;
                            hit_side_reg  <= ent_rd_reg.side;
                        end
                        if (!ent_rd_reg.valid && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= ridx_reg[EW-1:0];
                        end
                    end
                    if (scan_done) begin
                        cnt_reg      <= '0;
                        lm_found_reg <= 1'b0;
                        lf_found_reg <= 1'b0;
                        case (cmd_reg.kind)
                            K_ADD: begin
                                if (hit_found_reg) begin
                                    state_reg <= S_DSCAN;
                                end else if (free_found_reg) begin
                                    state_reg <= S_ASCAN;
                                end else begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_FIN;
                                end
                            end
                            K_REMOVE: begin
                                if (hit_found_reg) begin
                                    state_reg <= S_DSCAN;
                                end else begin
                                    status_reg <= ST_NOT_FOUND;
                                    state_reg  <= S_FIN;
                                end
                            end
                            K_MODIFY: begin
                                if (!hit_found_reg) begin
                                    status_reg <= ST_NOT_FOUND;
                                end
                                state_reg <= S_FIN;
                            end
                            default: begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DSCAN, S_ASCAN: begin
                    if (rv_reg) begin
                        if (lvl_rd_reg.valid && lvl_rd_reg.price == lv_price_want &&
                            lvl_rd_reg.side == lv_side_want && !lm_found_reg) begin
                            lm_found_reg <= 1'b1;
                            lm_idx_reg   <= ridx_reg[LW-1:0];
                            lm_cnt_reg   <= lvl_rd_reg.count;
                        end
                        if (!lvl_rd_reg.valid && !lf_found_reg) begin
                            lf_found_reg <= 1'b1;
                            lf_idx_reg   <= ridx_reg[LW-1:0];
                        end
                    end
                    if (scan_done) begin
                        cnt_reg      <= '0;
                        lm_found_reg <= 1'b0;
                        lf_found_reg <= 1'b0;
                        bid_acc_reg  <= NO_BID;
                        ask_acc_reg  <= NO_ASK;
                        if (state_reg == S_DSCAN && cmd_reg.kind == K_ADD) begin
                            // the freed slot competes for lowest free entry
                            if (!(free_found_reg && free_idx_reg < hit_idx_reg)) begin
                                free_idx_reg <= hit_idx_reg;
                            end
                            free_found_reg <= 1'b1;
                            state_reg      <= S_ASCAN;
                        end else begin
                            if (state_reg == S_ASCAN && !lm_found_reg && !lf_found_reg) begin
                                status_reg <= ST_FULL;
                            end
                            state_reg <= S_TSCAN;
                        end
                    end
                end
                S_TSCAN: begin
                    if (rv_reg && lvl_rd_reg.valid) begin
                        if (lvl_rd_reg.side) begin
                            if (lvl_rd_reg.price > bid_acc_reg) begin
                                bid_acc_reg <= lvl_rd_reg.price;
                            end
                        end else if (lvl_rd_reg.price < ask_acc_reg) begin
                            ask_acc_reg <= lvl_rd_reg.price;
                        end
                    end
                    if (scan_done) begin
                        top_bid_reg <= bid_acc_reg;
                        top_ask_reg <= ask_acc_reg;
                        state_reg   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        m_valid_reg  <= 1'b1;
                        m_bid_reg    <= top_bid_reg;
                        m_ask_reg    <= top_ask_reg;
                        m_status_reg <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_best_bid = m_bid_reg;
    assign m_best_ask = m_ask_reg;
    assign m_status   = m_status_reg;

    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !q_pop) else $error("command taken during clear");
    a_rose_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result loaded outside finish");
    a_full_only_add: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && status_reg == ST_FULL |-> cmd_reg.kind == K_ADD)
        else $error("full status on non-add");
    a_single_mem_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ent_we && state_reg == S_ESCAN |-> cmd_reg.kind == K_MODIFY)
        else $error("unexpected entry write in lookup");

endmodule

// ===== design/limit_order_book_levels_unit.sv =====
// Price-level order book. Each word on the s_ channel is one command (add, remove,
// modify quantity) and gives exactly one word on the m_ channel with the best bid,
// best ask and a status. After reset the order and level tables are swept clear,
// one entry a cycle; words are queued but not executed meanwhile. A command then
// does the id lookup (one entry-memory read a cycle), then level-memory passes:
// one for a remove, one for an add, two for an add that replaces a live id, and
// one more for the best-price rescan after any remove or add. A modify, an unused
// command code, a remove of an unknown id or an add with no free entry finishes
// after the lookup. The back takes the word from the queue in its idle state and
// loads the result in its finish state. A two-word queue sits between the
// accepting front and the executing back, and the result register lets the back
// start the next command while a result waits on m_ready.
module limit_order_book_levels_unit
    import lobl_pkg::*;
#(
    parameter int MAX_ORDERS = 1024,
    parameter int MAX_LEVELS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [KEY_W-1:0]   s_order_key,
    input  logic [PRICE_W-1:0] s_limit_price,
    input  logic [QTY_W-1:0]   s_order_size,
    input  logic               s_buy_side,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PRICE_W-1:0] m_best_bid,
    output logic [PRICE_W-1:0] m_best_ask,
    output logic [1:0]         m_status
);

    logic      q_valid;
    logic      q_pop;
    cmd_word_t q_word;

    // front: accept and decode
    lobl_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_order_key   (s_order_key),
        .s_limit_price (s_limit_price),
        .s_order_size  (s_order_size),
        .s_buy_side    (s_buy_side),
        .q_valid       (q_valid),
        .q_word        (q_word),
        .q_pop         (q_pop)
    );

    // back: table walks, updates and best-price rescan
    lobl_engine #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_best_bid (m_best_bid),
        .m_best_ask (m_best_ask),
        .m_status   (m_status)
    );

endmodule

// ===== verif/lobl_book_checker.sv =====
module lobl_book_checker
    import lobl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [KEY_W-1:0]   s_order_key,
    input  logic [PRICE_W-1:0] s_limit_price,
    input  logic [QTY_W-1:0]   s_order_size,
    input  logic               s_buy_side,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [PRICE_W-1:0] m_best_bid,
    input  logic [PRICE_W-1:0] m_best_ask,
    input  logic [1:0]         m_status,
    output int                 fail_count,
    output int                 pending
);

    localparam int N_ORD = 1024;
    localparam int N_LVL = 256;

    typedef struct packed {
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [1:0]         status;
    } book_top_t;

    book_top_t top_q[$];

    logic               ord_live [N_ORD];
    logic [KEY_W-1:0]   ord_key  [N_ORD];
    logic [PRICE_W-1:0] ord_price[N_ORD];
    logic [QTY_W-1:0]   ord_qty  [N_ORD];
    logic               ord_side [N_ORD];
    logic               lvl_live [N_LVL];
    logic [PRICE_W-1:0] lvl_price[N_LVL];
    logic               lvl_side [N_LVL];
    int                 lvl_cnt  [N_LVL];

    function automatic int find_order(logic [KEY_W-1:0] k);
        for (int i = 0; i < N_ORD; i++)
            if (ord_live[i] && ord_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int find_level(logic [PRICE_W-1:0] p, logic sd);
        for (int i = 0; i < N_LVL; i++)
            if (lvl_live[i] && lvl_price[i] == p && lvl_side[i] == sd) return i;
        return -1;
    endfunction

    function automatic void cancel_order(int e);
        int lv;
        lv = find_level(ord_price[e], ord_side[e]);
        if (lv >= 0) begin
            if (lvl_cnt[lv] > 0) lvl_cnt[lv]--;
            if (lvl_cnt[lv] == 0) lvl_live[lv] = 1'b0;
        end
        ord_live[e] = 1'b0;
    endfunction

    function automatic logic [1:0] place_order(logic [KEY_W-1:0] k, logic [PRICE_W-1:0] p,
                                               logic [QTY_W-1:0] q, logic sd);
        int old;
        int e;
        int lv;
        old = find_order(k);
        e = -1;
        if (old >= 0) cancel_order(old);
        for (int i = 0; i < N_ORD; i++)
            if (!ord_live[i]) begin
                e = i;
                break;
            end
        if (e < 0) return ST_FULL;
        lv = find_level(p, sd);
        if (lv < 0) begin
            for (int i = 0; i < N_LVL; i++)
                if (!lvl_live[i]) begin
                    lv = i;
                    break;
                end
            if (lv < 0) return ST_FULL;
            lvl_live[lv] = 1'b1;
            lvl_price[lv] = p;
            lvl_side[lv] = sd;
            lvl_cnt[lv] = 0;
        end
        lvl_cnt[lv]++;
        ord_live[e] = 1'b1;
        ord_key[e] = k;
        ord_price[e] = p;
        ord_qty[e] = q;
        ord_side[e] = sd;
        return ST_APPLIED;
    endfunction

    function automatic book_top_t apply_command(logic [1:0] c, logic [KEY_W-1:0] k,
                                                logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q,
                                                logic sd);
        book_top_t r;
        int e;
        r.status = ST_APPLIED;
        if (c == CMD_ADD) begin
            r.status = place_order(k, p, q, sd);
        end else if (c == CMD_REMOVE || c == CMD_MODIFY) begin
            e = find_order(k);
            if (e < 0) r.status = ST_NOT_FOUND;
            else if (c == CMD_REMOVE) cancel_order(e);
            else ord_qty[e] = q;
        end
        r.bid = NO_BID;
        r.ask = NO_ASK;
        for (int i = 0; i < N_LVL; i++) begin
            if (!lvl_live[i]) continue;
            if (lvl_side[i]) begin
                if (lvl_price[i] > r.bid) r.bid = lvl_price[i];
            end else if (lvl_price[i] < r.ask) begin
                r.ask = lvl_price[i];
            end
        end
        return r;
    endfunction

    assign pending = top_q.size();

    always @(posedge aclk) begin
        book_top_t exp_w;
        if (!aresetn) begin
            top_q.delete();
            fail_count <= 0;
            for (int i = 0; i < N_ORD; i++) ord_live[i] = 1'b0;
            for (int i = 0; i < N_LVL; i++) lvl_live[i] = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (top_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: result word with nothing outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = top_q.pop_front();
                    if (exp_w.bid !== m_best_bid || exp_w.ask !== m_best_ask ||
                        exp_w.status !== m_status) begin
                        if (fail_count < 10)
                            $display("ERROR: bid %h/%h ask %h/%h status %0d/%0d (exp/got)",
                                     exp_w.bid, m_best_bid, exp_w.ask, m_best_ask,
                                     exp_w.status, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                top_q.push_back(apply_command(s_command, s_order_key, s_limit_price,
                                              s_order_size, s_buy_side));
        end
    end

endmodule

// ===== verif/tb_limit_order_book_levels_unit.sv =====
module tb_limit_order_book_levels_unit;
    import lobl_pkg::*;

    // idle cycles with no word on either side before giving up
    localparam int WATCHDOG = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int N_KEYS = 48;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_ADD;
    logic [KEY_W-1:0]   s_order_key = '0;
    logic [PRICE_W-1:0] s_limit_price = '0;
    logic [QTY_W-1:0]   s_order_size = '0;
    logic               s_buy_side = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PRICE_W-1:0] m_best_bid;
    logic [PRICE_W-1:0] m_best_ask;
    logic [1:0]         m_status;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;     // back-to-back stretch on both sides
    bit hold_req = 1'b0;    // receiver parks m_ready low for a long spell

    logic [KEY_W-1:0]   key_pool[N_KEYS];
    logic [PRICE_W-1:0] price_pool[16];
    logic [KEY_W-1:0]   filled_keys[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    limit_order_book_levels_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_order_key(s_order_key), .s_limit_price(s_limit_price),
        .s_order_size(s_order_size), .s_buy_side(s_buy_side),
        .m_valid(m_valid), .m_ready(m_ready), .m_best_bid(m_best_bid),
        .m_best_ask(m_best_ask), .m_status(m_status)
    );

    lobl_book_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_order_key(s_order_key), .s_limit_price(s_limit_price),
        .s_order_size(s_order_size), .s_buy_side(s_buy_side),
        .m_valid(m_valid), .m_ready(m_ready), .m_best_bid(m_best_bid),
        .m_best_ask(m_best_ask), .m_status(m_status),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one word, hold it until taken, then idle for a random gap;
    // valid is only dropped when a gap follows, so it never toggles in one step
    task automatic send_word(logic [1:0] c, logic [KEY_W-1:0] k, logic [PRICE_W-1:0] p,
                             logic [QTY_W-1:0] q, logic sd);
        int gap;
        s_valid <= 1'b1;
        s_command <= c;
        s_order_key <= k;
        s_limit_price <= p;
        s_order_size <= q;
        s_buy_side <= sd;
        do @(posedge aclk); while (!s_ready);
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // random command with content drawn from the pools, so ids hit often
    task automatic send_random();
        logic [1:0] c;
        logic [KEY_W-1:0] k;
        int r;
        r = $urandom_range(0, 99);
        c = (r < 50) ? CMD_ADD : (r < 75) ? CMD_REMOVE : (r < 97) ? CMD_MODIFY : CMD_UNUSED;
        k = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, N_KEYS - 1)];
        send_word(c, k, price_pool[$urandom_range(0, 15)], $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    // receiver: random stalls per word, or a long hold when asked
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // watchdog on words moved on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int idx;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < N_KEYS; i++) key_pool[i] = rand64();
        price_pool[0] = '0;
        price_pool[1] = '1;
        for (int i = 2; i < 8; i++) price_pool[i] = 32'd1000 + $urandom_range(0, 20);
        for (int i = 8; i < 16; i++) price_pool[i] = $urandom;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty book, extremes, duplicate id, zero qty, unknown ids, cmd 3
        send_word(CMD_REMOVE, key_pool[0], '0, '0, 1'b0);
        send_word(CMD_MODIFY, key_pool[1], '0, '1, 1'b1);
        send_word(CMD_ADD, key_pool[0], '0, '0, 1'b1);
        send_word(CMD_ADD, key_pool[1], '1, '1, 1'b0);
        send_word(CMD_ADD, key_pool[2], '1, 32'd5, 1'b1);
        send_word(CMD_ADD, key_pool[3], '0, 32'd7, 1'b0);
        send_word(CMD_ADD, key_pool[4], 32'd500, '0, 1'b1);
        send_word(CMD_ADD, key_pool[5], 32'd500, 32'd9, 1'b1);
        send_word(CMD_ADD, key_pool[6], 32'd600, 32'd3, 1'b0);
        send_word(CMD_MODIFY, key_pool[4], 32'd1, 32'hdead_beef, 1'b0);
        send_word(CMD_ADD, key_pool[4], 32'd700, 32'd1, 1'b0);   // live id reused
        send_word(CMD_ADD, key_pool[2], 32'd800, 32'd2, 1'b1);   // reuse closes top bid
        send_word(CMD_UNUSED, key_pool[2], '1, '1, 1'b1);
        send_word(CMD_REMOVE, key_pool[3], '0, '0, 1'b0);
        send_word(CMD_REMOVE, key_pool[3], '0, '0, 1'b0);        // already gone
        send_word(CMD_REMOVE, key_pool[5], '0, '0, 1'b0);
        send_word(CMD_REMOVE, key_pool[2], '0, '0, 1'b0);
        send_word(CMD_MODIFY, rand64(), '0, '1, 1'b0);

        // random mix, with a back-to-back stretch and a long receiver hold
        for (int i = 0; i < 380; i++) begin
            if (i == 100) no_idle = 1'b1;
            if (i == 160) no_idle = 1'b0;
            if (i == 200) hold_req = 1'b1;
            send_random();
        end

        // fill the level table past its size: fresh ids at distinct prices
        for (int i = 0; i < 290; i++) begin
            filled_keys.push_back(rand64());
            send_word(CMD_ADD, filled_keys[i], 32'h4000_0000 + i, $urandom,
                      1'($urandom_range(0, 1)));
        end

        // drain the filled levels again, interleaved with noise
        for (int i = 0; i < 470; i++) begin
            if (filled_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
                idx = $urandom_range(0, filled_keys.size() - 1);
                send_word(($urandom_range(0, 4) == 0) ? CMD_MODIFY : CMD_REMOVE,
                          filled_keys[idx], $urandom, $urandom,
                          1'($urandom_range(0, 1)));
                filled_keys.delete(idx);
            end else begin
                send_random();
            end
        end

        if (s_valid) s_valid <= 1'b0;
        // let the checker log the last word before looking at what is outstanding
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/lobl_pkg.sv
design/lobl_front.sv
design/lobl_engine.sv
design/limit_order_book_levels_unit.sv
verif/lobl_book_checker.sv
verif/tb_limit_order_book_levels_unit.sv
